// File: rtl/eva_pkg.sv
// ----------------------------------------------------------------------------
// eva_pkg
// Shared types, codes and the microcode store of the eased value animator.
// ----------------------------------------------------------------------------
package eva_pkg;

    // Command codes carried by each input transaction
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET      = 2'd1,
        OP_RETARGET = 2'd2,
        OP_RESTART  = 2'd3
    } t_opcode;

    // Easing curve codes (configuration register)
    typedef enum logic [2:0] {
        CURVE_LINEAR      = 3'd0,
        CURVE_IN_QUAD     = 3'd1,
        CURVE_OUT_QUAD    = 3'd2,
        CURVE_INOUT_QUAD  = 3'd3,
        CURVE_IN_CUBIC    = 3'd4,
        CURVE_OUT_CUBIC   = 3'd5,
        CURVE_INOUT_CUBIC = 3'd6,
        CURVE_SMOOTHSTEP  = 3'd7
    } t_curve;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP,
        U_DIVI,     // load divider remainder
        U_DIV,      // one restoring divide step
        U_X_2MT,    // x = 2 - t
        U_X_4M2T,   // x = 4 - 2t
        U_X_1MT,    // x = 1 - t
        U_X_3M2T,   // x = 3 - 2t
        U_M_TT,     // m = t*t
        U_M_TX,     // m = t*x
        U_M_XX,     // m = x*x
        U_M_MT,     // m = m*t
        U_M_MX,     // m = m*x
        U_P_T,      // p = t
        U_P_M,      // p = m
        U_P_M2,     // p = 2m
        U_P_MM1,    // p = m - 1
        U_P_1MM,    // p = 1 - m
        U_P_M4,     // p = 4m
        U_P_1M4M,   // p = 1 - 4m
        U_FIN,      // product = (target - start) * p
        U_OUT       // scale, truncate and write back
    } t_uop;

    // Sequencer branch kinds
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_DIVLOOP,
        BR_CURVE,
        BR_END
    } t_br;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_uop uop;
        t_br  br;
        t_pc  target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic busy;
        t_uop uop;
    } t_seq_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic t_ge_half;
    } t_dp_stat;

    // Program entry points
    localparam t_pc A_START     = 6'd0;
    localparam t_pc A_LIN       = 6'd3;
    localparam t_pc A_IN_QUAD   = 6'd4;
    localparam t_pc A_OUT_QUAD  = 6'd6;
    localparam t_pc A_IOQ_LO    = 6'd9;
    localparam t_pc A_IOQ_HI    = 6'd11;
    localparam t_pc A_IN_CUBIC  = 6'd14;
    localparam t_pc A_OUT_CUBIC = 6'd17;
    localparam t_pc A_IOC_LO    = 6'd21;
    localparam t_pc A_IOC_HI    = 6'd24;
    localparam t_pc A_SMOOTH    = 6'd28;
    localparam t_pc A_FIN       = 6'd32;

    // Microcode store
    function automatic t_uword ucode_word(input t_pc pc);
        t_uword w;
        unique case (pc)
            6'd0:    w = '{U_DIVI,   BR_NEXT,    A_START};
            6'd1:    w = '{U_DIV,    BR_DIVLOOP, A_START};
            6'd2:    w = '{U_NOP,    BR_CURVE,   A_START};
            // linear
            6'd3:    w = '{U_P_T,    BR_GOTO,    A_FIN};
            // in-quad
            6'd4:    w = '{U_M_TT,   BR_NEXT,    A_START};
            6'd5:    w = '{U_P_M,    BR_GOTO,    A_FIN};
            // out-quad
            6'd6:    w = '{U_X_2MT,  BR_NEXT,    A_START};
            6'd7:    w = '{U_M_TX,   BR_NEXT,    A_START};
            6'd8:    w = '{U_P_M,    BR_GOTO,    A_FIN};
            // in-out quad, first half
            6'd9:    w = '{U_M_TT,   BR_NEXT,    A_START};
            6'd10:   w = '{U_P_M2,   BR_GOTO,    A_FIN};
            // in-out quad, second half
            6'd11:   w = '{U_X_4M2T, BR_NEXT,    A_START};
            6'd12:   w = '{U_M_TX,   BR_NEXT,    A_START};
            6'd13:   w = '{U_P_MM1,  BR_GOTO,    A_FIN};
            // in-cubic
            6'd14:   w = '{U_M_TT,   BR_NEXT,    A_START};
            6'd15:   w = '{U_M_MT,   BR_NEXT,    A_START};
            6'd16:   w = '{U_P_M,    BR_GOTO,    A_FIN};
            // out-cubic
            6'd17:   w = '{U_X_1MT,  BR_NEXT,    A_START};
            6'd18:   w = '{U_M_XX,   BR_NEXT,    A_START};
            6'd19:   w = '{U_M_MX,   BR_NEXT,    A_START};
            6'd20:   w = '{U_P_1MM,  BR_GOTO,    A_FIN};
            // in-out cubic, first half
            6'd21:   w = '{U_M_TT,   BR_NEXT,    A_START};
            6'd22:   w = '{U_M_MT,   BR_NEXT,    A_START};
            6'd23:   w = '{U_P_M4,   BR_GOTO,    A_FIN};
            // in-out cubic, second half
            6'd24:   w = '{U_X_1MT,  BR_NEXT,    A_START};
            6'd25:   w = '{U_M_XX,   BR_NEXT,    A_START};
            6'd26:   w = '{U_M_MX,   BR_NEXT,    A_START};
            6'd27:   w = '{U_P_1M4M, BR_GOTO,    A_FIN};
            // smoothstep
            6'd28:   w = '{U_X_3M2T, BR_NEXT,    A_START};
            6'd29:   w = '{U_M_TT,   BR_NEXT,    A_START};
            6'd30:   w = '{U_M_MX,   BR_NEXT,    A_START};
            6'd31:   w = '{U_P_M,    BR_GOTO,    A_FIN};
            // common tail
            6'd32:   w = '{U_FIN,    BR_NEXT,    A_START};
            6'd33:   w = '{U_OUT,    BR_END,     A_START};
            default: w = '{U_NOP,    BR_END,     A_START};
        endcase
        return w;
    endfunction

    // Curve dispatch: entry point from curve code and half of t
    function automatic t_pc curve_entry(input t_curve curve, input logic ge_half);
        t_pc a;
        unique case (curve)
            CURVE_LINEAR:      a = A_LIN;
            CURVE_IN_QUAD:     a = A_IN_QUAD;
            CURVE_OUT_QUAD:    a = A_OUT_QUAD;
            CURVE_INOUT_QUAD:  a = ge_half ? A_IOQ_HI : A_IOQ_LO;
            CURVE_IN_CUBIC:    a = A_IN_CUBIC;
            CURVE_OUT_CUBIC:   a = A_OUT_CUBIC;
            CURVE_INOUT_CUBIC: a = ge_half ? A_IOC_HI : A_IOC_LO;
            CURVE_SMOOTHSTEP:  a = A_SMOOTH;
            default:           a = A_LIN;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/eased_value_animator.sv
// ----------------------------------------------------------------------------
// eased_value_animator
// Animates a signed 16-bit value along a selectable easing curve.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one command per
// transaction: tick, hard set, soft retarget or restart. Every command gives
// exactly one result transaction on the output channel (o_out_valid /
// i_out_ready): the present value and the running flag after the command.
// Commands other than an advancing tick, and ticks that are idle or finish
// the animation, answer in the cycle after acceptance. An advancing tick runs
// the microcode program: a load step for the divider, FRACTION_BITS divide
// steps, one dispatch step, one to four curve steps, then the final multiply
// and write-back, after which the result is offered. The serial divider for
// t = tick / limit dominates. A new command is taken once the program is
// idle and the result slot is empty or being read in the same cycle. While
// the receiver stalls, the result holds and no command is accepted. Reset
// clears the animation and sequencer state to zero and idle, the curve select
// to linear. The curve select is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module eased_value_animator #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic signed [15:0]  i_value,
    input  logic [15:0]         i_duration,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_current_value,
    output logic                o_running
);

    logic signed [15:0] r_present, n_present;
    logic signed [15:0] r_start,   n_start;
    logic signed [15:0] r_target,  n_target;
    logic [15:0]        r_count,   n_count;
    logic [15:0]        r_limit,   n_limit;
    logic               r_active,  n_active;
    logic               r_out_valid, n_out_valid;
    eva_pkg::t_curve    r_curve,   n_curve;

    eva_pkg::t_seq_ctrl seq_ctrl;
    eva_pkg::t_dp_stat  dp_stat;
    logic signed [15:0] dp_result;
    logic               in_fire;
    logic               seq_start;
    eva_pkg::t_opcode   op;

    assign op         = eva_pkg::t_opcode'(i_opcode);
    assign o_in_ready = !seq_ctrl.busy && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    // Microcode sequencer
    eva_sequencer #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seq_start),
        .i_curve (r_curve),
        .i_stat  (dp_stat),
        .o_ctrl  (seq_ctrl)
    );

    // Arithmetic datapath
    eva_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_ctrl   (seq_ctrl),
        .i_count  (r_count),
        .i_limit  (r_limit),
        .i_start  (r_start),
        .i_target (r_target),
        .o_stat   (dp_stat),
        .o_result (dp_result)
    );

    // Command handling and animation state
    always_comb begin
        n_present   = r_present;
        n_start     = r_start;
        n_target    = r_target;
        n_count     = r_count;
        n_limit     = r_limit;
        n_active    = r_active;
        n_curve     = r_curve;
        n_out_valid = r_out_valid && !i_out_ready;
        seq_start   = 1'b0;

        if (i_cfg_we) begin
            n_curve = eva_pkg::t_curve'(i_cfg_wdata);
        end

        if (in_fire) begin
            unique case (op)
                eva_pkg::OP_TICK: begin
                    if (r_active && (r_count < r_limit)) begin
                        seq_start = 1'b1;
                    end else begin
                        if (r_active) begin
                            n_present = r_target;
                            n_active  = 1'b0;
                        end
                        n_out_valid = 1'b1;
                    end
                end
                eva_pkg::OP_SET: begin
                    n_present   = i_value;
                    n_start     = i_value;
                    n_target    = i_value;
                    n_count     = '0;
                    n_active    = 1'b0;
                    n_out_valid = 1'b1;
                end
                eva_pkg::OP_RETARGET: begin
                    n_target    = i_value;
                    n_limit     = i_duration;
                    n_count     = '0;
                    if (!r_active) begin
                        n_start  = r_present;
                        n_active = 1'b1;
                    end
                    n_out_valid = 1'b1;
                end
                eva_pkg::OP_RESTART: begin
                    n_start     = r_present;
                    n_target    = i_value;
                    n_limit     = i_duration;
                    n_count     = '0;
                    n_active    = 1'b1;
                    n_out_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Write-back of an advancing tick
        if (seq_ctrl.uop == eva_pkg::U_OUT) begin
            n_present   = dp_result;
            n_count     = r_count + 16'd1;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_start     <= '0;
            r_target    <= '0;
            r_count     <= '0;
            r_limit     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_curve     <= eva_pkg::CURVE_LINEAR;
        end else begin
            r_present   <= n_present;
            r_start     <= n_start;
            r_target    <= n_target;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_curve     <= n_curve;
        end
    end

    // State registers hold the result while it is offered
    assign o_out_valid     = r_out_valid;
    assign o_current_value = r_present;
    assign o_running       = r_active;

    // Checks
    a_seq_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && seq_start) |=> !o_out_valid)
        else $error("result offered before the tick program ran");

    a_wb_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctrl.uop == eva_pkg::U_OUT) |-> !r_out_valid)
        else $error("write-back while a result is still pending");

    a_wb_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctrl.uop == eva_pkg::U_OUT) |=> (o_out_valid && !seq_ctrl.busy))
        else $error("write-back did not offer a result");

    a_busy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctrl.busy |-> (r_count < r_limit))
        else $error("tick program running with count at or past limit");

endmodule

// File: rtl/eva_sequencer.sv
// ----------------------------------------------------------------------------
// eva_sequencer
// Microcode sequencer: step counter, divide loop counter and branch logic.
// ----------------------------------------------------------------------------
module eva_sequencer #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  eva_pkg::t_curve     i_curve,
    input  eva_pkg::t_dp_stat   i_stat,
    output eva_pkg::t_seq_ctrl  o_ctrl
);

    localparam int CNT_W = $clog2(FRACTION_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS - 1);

    logic             r_busy, n_busy;
    eva_pkg::t_pc     r_pc,   n_pc;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    eva_pkg::t_uword  word;

    assign word = eva_pkg::ucode_word(r_pc);

    // Next step selection
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_cnt  = r_cnt;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = eva_pkg::A_START;
                n_cnt  = '0;
            end
        end else begin
            unique case (word.br)
                eva_pkg::BR_NEXT:  n_pc = r_pc + 1'b1;
                eva_pkg::BR_GOTO:  n_pc = word.target;
                eva_pkg::BR_DIVLOOP: begin
                    // hold on the divide step for one pass per quotient bit
                    if (r_cnt == CNT_LAST) begin
                        n_pc  = r_pc + 1'b1;
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                eva_pkg::BR_CURVE: n_pc = eva_pkg::curve_entry(i_curve, i_stat.t_ge_half);
                eva_pkg::BR_END:   n_busy = 1'b0;
                default:           n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= eva_pkg::A_START;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
        end
    end

    // Control word out
    assign o_ctrl.busy = r_busy;
    assign o_ctrl.uop  = r_busy ? word.uop : eva_pkg::U_NOP;

endmodule

// File: rtl/eva_datapath.sv
// ----------------------------------------------------------------------------
// eva_datapath
// Serial divider, shared curve multiplier and final scaling for one tick.
// ----------------------------------------------------------------------------
module eva_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  eva_pkg::t_seq_ctrl  i_ctrl,
    input  logic [15:0]         i_count,
    input  logic [15:0]         i_limit,
    input  logic signed [15:0]  i_start,
    input  logic signed [15:0]  i_target,
    output eva_pkg::t_dp_stat   o_stat,
    output logic signed [15:0]  o_result
);

    localparam int F    = FRACTION_BITS;
    localparam int W_X  = F + 2;    // curve operands and products, below 4.0
    localparam int W_E  = F + 3;    // headroom for curve arithmetic
    localparam int W_P  = F + 1;    // eased position, 0.0 to 1.0
    localparam int W_PR = F + 19;   // (target - start) * p
    localparam int W_AC = F + 20;   // start * ONE + product

    localparam logic [W_E-1:0] ONE_E = {3'b001, {F{1'b0}}};
    localparam logic signed [W_AC-1:0] RND = {{(W_AC-F){1'b0}}, {F{1'b1}}};

    logic [15:0]             r_rem;
    logic [F-1:0]            r_t;
    logic [W_X-1:0]          r_x;
    logic [W_X-1:0]          r_m;
    logic [W_P-1:0]          r_p;
    logic signed [W_PR-1:0]  r_prod;

    // Restoring divide step
    logic [16:0] div_sh;
    logic        div_ge;
    logic [16:0] div_sub;
    assign div_sh  = {r_rem, 1'b0};
    assign div_ge  = div_sh >= {1'b0, i_limit};
    assign div_sub = div_sh - {1'b0, i_limit};

    // Curve helper terms
    logic [W_E-1:0] t_e, m_e, x_val, p_val;
    assign t_e = {3'b000, r_t};
    assign m_e = {1'b0, r_m};

    always_comb begin
        unique case (i_ctrl.uop)
            eva_pkg::U_X_2MT:  x_val = (ONE_E << 1) - t_e;
            eva_pkg::U_X_4M2T: x_val = (ONE_E << 2) - (t_e << 1);
            eva_pkg::U_X_3M2T: x_val = (ONE_E << 1) + ONE_E - (t_e << 1);
            default:           x_val = ONE_E - t_e;
        endcase
    end

    always_comb begin
        unique case (i_ctrl.uop)
            eva_pkg::U_P_T:    p_val = t_e;
            eva_pkg::U_P_M2:   p_val = m_e << 1;
            eva_pkg::U_P_MM1:  p_val = m_e - ONE_E;
            eva_pkg::U_P_1MM:  p_val = ONE_E - m_e;
            eva_pkg::U_P_M4:   p_val = m_e << 2;
            eva_pkg::U_P_1M4M: p_val = ONE_E - (m_e << 2);
            default:           p_val = m_e;
        endcase
    end

    // Shared truncating Q multiplier
    logic [W_X-1:0]   mul_a, mul_b;
    logic [2*W_X-1:0] mul_prod;
    always_comb begin
        unique case (i_ctrl.uop)
            eva_pkg::U_M_TX: begin mul_a = {2'b00, r_t}; mul_b = r_x;           end
            eva_pkg::U_M_XX: begin mul_a = r_x;          mul_b = r_x;           end
            eva_pkg::U_M_MT: begin mul_a = r_m;          mul_b = {2'b00, r_t};  end
            eva_pkg::U_M_MX: begin mul_a = r_m;          mul_b = r_x;           end
            default:         begin mul_a = {2'b00, r_t}; mul_b = {2'b00, r_t};  end
        endcase
    end
    assign mul_prod = mul_a * mul_b;

    // Final product: span times eased position
    logic signed [16:0]     diff;
    logic signed [W_P:0]    p_s;
    logic signed [W_PR-1:0] fin_prod;
    assign diff     = {i_target[15], i_target} - {i_start[15], i_start};
    assign p_s      = $signed({1'b0, r_p});
    assign fin_prod = diff * p_s;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.uop)
            eva_pkg::U_DIVI: begin
                r_rem <= i_count;
                r_t   <= '0;
            end
            eva_pkg::U_DIV: begin
                r_rem <= div_ge ? div_sub[15:0] : div_sh[15:0];
                r_t   <= {r_t[F-2:0], div_ge};
            end
            eva_pkg::U_X_2MT, eva_pkg::U_X_4M2T, eva_pkg::U_X_1MT,
            eva_pkg::U_X_3M2T: begin
                r_x <= x_val[W_X-1:0];
            end
            eva_pkg::U_M_TT, eva_pkg::U_M_TX, eva_pkg::U_M_XX,
            eva_pkg::U_M_MT, eva_pkg::U_M_MX: begin
                r_m <= mul_prod[F +: W_X];
            end
            eva_pkg::U_P_T, eva_pkg::U_P_M, eva_pkg::U_P_M2, eva_pkg::U_P_MM1,
            eva_pkg::U_P_1MM, eva_pkg::U_P_M4, eva_pkg::U_P_1M4M: begin
                r_p <= p_val[W_P-1:0];
            end
            eva_pkg::U_FIN: begin
                r_prod <= fin_prod;
            end
            default: begin
            end
        endcase
    end

    // Scale back, truncating toward zero
    logic signed [W_AC-1:0] start_e, acc, adj, shifted;
    assign start_e  = {{(W_AC-16){i_start[15]}}, i_start};
    assign acc      = (start_e <<< F) + {r_prod[W_PR-1], r_prod};
    assign adj      = acc[W_AC-1] ? (acc + RND) : acc;
    assign shifted  = adj >>> F;
    assign o_result = shifted[15:0];

    assign o_stat.t_ge_half = r_t[F-1];

endmodule

// File: tb/eva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eva_checker
// Watches both channels of the eased value animator and checks each result.
// ----------------------------------------------------------------------------
// Keeps its own copy of the animation state and curve select, updates it on
// every accepted command transaction and queues the value and running flag
// that the command should report. Each accepted result transaction is checked
// against the oldest queued entry. The failure count and the number of
// results still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module eva_checker #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic signed [15:0]  i_value,
    input  logic [15:0]         i_duration,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic signed [15:0]  i_current_value,
    input  logic                i_running,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam longint UNITY = longint'(1) << FRACTION_BITS;

    typedef struct packed {
        logic signed [15:0] value;
        logic               running;
    } t_frame;

    // Model of the animation state
    logic signed [15:0] anim_value;
    logic signed [15:0] anim_start;
    logic signed [15:0] anim_target;
    logic [15:0]        anim_tick;
    logic [15:0]        anim_limit;
    logic               anim_active;
    eva_pkg::t_curve    curve_sel;

    t_frame expected_frames[$];
    int     mismatches = 0;

    // Truncating fixed-point product of two non-negative fractions
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FRACTION_BITS;
    endfunction

    // Eased progress p(t), both in units of UNITY
    function automatic longint curve_fraction(input eva_pkg::t_curve c, input longint t);
        longint half;
        longint rem;
        half = UNITY >>> 1;
        rem  = UNITY - t;
        case (c)
            eva_pkg::CURVE_IN_QUAD:     return fx_mul(t, t);
            eva_pkg::CURVE_OUT_QUAD:    return fx_mul(t, 2 * UNITY - t);
            eva_pkg::CURVE_INOUT_QUAD:
                if (t < half) return 2 * fx_mul(t, t);
                else return fx_mul(4 * UNITY - 2 * t, t) - UNITY;
            eva_pkg::CURVE_IN_CUBIC:    return fx_mul(fx_mul(t, t), t);
            eva_pkg::CURVE_OUT_CUBIC:   return UNITY - fx_mul(fx_mul(rem, rem), rem);
            eva_pkg::CURVE_INOUT_CUBIC:
                if (t < half) return 4 * fx_mul(fx_mul(t, t), t);
                else return UNITY - 4 * fx_mul(fx_mul(rem, rem), rem);
            eva_pkg::CURVE_SMOOTHSTEP:  return fx_mul(fx_mul(t, t), 3 * UNITY - 2 * t);
            default:                    return t;
        endcase
    endfunction

    // Apply one command to the model and give the frame it reports
    task automatic apply_command(input eva_pkg::t_opcode op,
                                 input logic signed [15:0] val,
                                 input logic [15:0] dur, output t_frame frame);
        longint t;
        longint p;
        longint acc;
        case (op)
            eva_pkg::OP_TICK: begin
                if (anim_active) begin
                    if (anim_tick >= anim_limit) begin
                        anim_value  = anim_target;
                        anim_active = 1'b0;
                    end else begin
                        t   = (longint'(anim_tick) << FRACTION_BITS) / longint'(anim_limit);
                        p   = curve_fraction(curve_sel, t);
                        acc = longint'(anim_start) * UNITY
                            + (longint'(anim_target) - longint'(anim_start)) * p;
                        // signed division truncates toward zero
                        anim_value = 16'(acc / UNITY);
                        anim_tick  = anim_tick + 16'd1;
                    end
                end
            end
            eva_pkg::OP_SET: begin
                anim_value  = val;
                anim_start  = val;
                anim_target = val;
                anim_tick   = '0;
                anim_active = 1'b0;
            end
            eva_pkg::OP_RETARGET: begin
                anim_target = val;
                anim_limit  = dur;
                anim_tick   = '0;
                // start point only moves when not already animating
                if (!anim_active) begin
                    anim_start  = anim_value;
                    anim_active = 1'b1;
                end
            end
            default: begin
                anim_start  = anim_value;
                anim_target = val;
                anim_limit  = dur;
                anim_tick   = '0;
                anim_active = 1'b1;
            end
        endcase
        frame.value   = anim_value;
        frame.running = anim_active;
    endtask

    task automatic flag_error(input string msg);
        mismatches += 1;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    // Sample both channels on every rising edge
    always @(posedge i_clk) begin : watch
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            anim_value  = '0;
            anim_start  = '0;
            anim_target = '0;
            anim_tick   = '0;
            anim_limit  = '0;
            anim_active = 1'b0;
            curve_sel   = eva_pkg::CURVE_LINEAR;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) curve_sel = eva_pkg::t_curve'(i_cfg_wdata);

            // result transaction
            if (i_out_valid && i_out_ready) begin
                got.value   = i_current_value;
                got.running = i_running;
                if (expected_frames.size() == 0) begin
                    flag_error($sformatf(
                        "result with nothing outstanding: value %0d running %0b",
                        got.value, got.running));
                end else begin
                    want = expected_frames.pop_front();
                    if (got.value !== want.value || got.running !== want.running)
                        flag_error($sformatf(
                            "expected value %0d running %0b, got value %0d running %0b",
                            want.value, want.running, got.value, got.running));
                end
            end

            // command transaction
            if (i_in_valid && i_in_ready) begin
                apply_command(eva_pkg::t_opcode'(i_opcode), i_value, i_duration, want);
                expected_frames.push_back(want);
            end
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb_eased_value_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eased_value_animator
// Stimulus and verdict for the eased value animator.
// ----------------------------------------------------------------------------
// Drives a short directed sequence over every command and the corner cases
// (idle tick, zero and maximum duration, retarget while running, hard set
// mid-animation), then random phases over all curve settings, made mostly of
// complete animations with random targets and lengths plus some noise. The
// sender runs in bursts with random gaps; the receiver stalls in changing
// modes. Checking is done by eva_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_eased_value_animator;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_STROBE
    } t_rx_mode;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [2:0]         i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_opcode    = '0;
    logic signed [15:0] i_value     = '0;
    logic [15:0]        i_duration  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_current_value;
    logic               o_running;

    int       fail_count;
    int       pending;
    int       burst_left    = 0;
    int       commands_sent = 0;
    t_rx_mode rx_mode       = RX_FREE;
    int       rx_mode_left  = 0;
    int       rx_cycle      = 0;

    always #1 i_clk = ~i_clk;

    eased_value_animator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_duration      (i_duration),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_current_value (o_current_value),
        .o_running       (o_running)
    );

    eva_checker animation_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_duration      (i_duration),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_current_value (o_current_value),
        .i_running       (o_running),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver back-pressure: switches between stall modes every so often
    always @(posedge i_clk) begin
        rx_cycle += 1;
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 300);
        end
        rx_mode_left -= 1;
        case (rx_mode)
            RX_FREE:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:  i_out_ready <= ((rx_cycle & 7) == 0);
        endcase
    end

    // One command transaction; opens a new burst after a random gap
    task automatic send_cmd(input eva_pkg::t_opcode op, input logic [15:0] val,
                            input logic [15:0] dur);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left -= 1;
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_duration <= dur;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        commands_sent += 1;
    endtask

    // Wait until every result is back, then switch curve
    task automatic set_curve(input eva_pkg::t_curve c);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Target values weighted toward the extremes, zero and minus one
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short animations, some long, a few anywhere in range
    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 20));
        else if (r < 9) return 16'($urandom_range(21, 400));
        else if ($urandom_range(0, 1) == 0) return 16'hFFFF;
        else return 16'($urandom);
    endfunction

    initial begin : stimulus
        int phase;
        int phase_start;
        int ticks;
        logic [15:0] dur;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick, extreme set values, zero duration
        send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_cmd(eva_pkg::OP_SET, 16'h7FFF, 16'hFFFF);
        send_cmd(eva_pkg::OP_SET, 16'h8000, 16'h0000);
        send_cmd(eva_pkg::OP_RESTART, 16'h7FFF, 16'h0000);
        send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        // retarget from idle, then retarget while running keeps the start
        send_cmd(eva_pkg::OP_RETARGET, 16'h8000, 16'd4);
        repeat (2) send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_cmd(eva_pkg::OP_RETARGET, 16'h0000, 16'd3);
        repeat (4) send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        // longest duration, then hard set in the middle of it
        send_cmd(eva_pkg::OP_RESTART, 16'd12345, 16'hFFFF);
        repeat (2) send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_cmd(eva_pkg::OP_SET, 16'hFFFF, 16'h0000);
        send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);
        // single-tick animation
        send_cmd(eva_pkg::OP_RESTART, 16'h7FFF, 16'd1);
        repeat (2) send_cmd(eva_pkg::OP_TICK, 16'h0000, 16'h0000);

        // Random phases, each on its own curve; all curves in the first eight
        for (phase = 0; phase < 16; phase++) begin
            set_curve(phase < 8 ? eva_pkg::t_curve'(phase)
                                : eva_pkg::t_curve'($urandom_range(0, 7)));
            phase_start = commands_sent;
            while (commands_sent - phase_start < 105) begin
                if ($urandom_range(0, 9) < 7) begin
                    // complete animation, sometimes cut short by another command
                    dur = pick_duration();
                    send_cmd($urandom_range(0, 1) ? eva_pkg::OP_RESTART
                                                  : eva_pkg::OP_RETARGET,
                             pick_value(), dur);
                    ticks = (dur < 38) ? int'(dur) + $urandom_range(1, 3)
                                       : $urandom_range(1, 40);
                    repeat (ticks) begin
                        if ($urandom_range(0, 19) == 0)
                            send_cmd(eva_pkg::t_opcode'($urandom_range(1, 3)),
                                     pick_value(), pick_duration());
                        send_cmd(eva_pkg::OP_TICK, 16'($urandom), 16'($urandom));
                    end
                end else begin
                    // noise: any command with any fields
                    send_cmd(eva_pkg::t_opcode'($urandom_range(0, 3)), 16'($urandom),
                             16'($urandom));
                end
            end
        end

        // Drain, then allow for a stray late result
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (30) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/eva_pkg.sv
rtl/eva_sequencer.sv
rtl/eva_datapath.sv
rtl/eased_value_animator.sv
tb/eva_checker.sv
tb/tb_eased_value_animator.sv
